@@ design/assert_macros.svh @@
// Assertion macros used by the top level of the point transform block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Checked at every clock edge outside reset.
`define ASSERT_CHK(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
// Checked at every clock edge, reset included.
`define ASSERT_ALW(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");
`else
`define ASSERT_CHK(lbl, clk, rst, prop)
`define ASSERT_ALW(lbl, clk, prop)
`endif
`endif

@@ design/rpt_pkg.sv @@
// Shared types and constants of the rigid point transform block.
package rpt_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int COEF_WIDTH  = 16;
  localparam int FRAC_BITS   = COEF_WIDTH - 2;
  localparam int AXES        = 3;
  localparam int ROW_W       = AXES * COEF_WIDTH;
  localparam int CFG_W       = (ROW_W > COORD_WIDTH) ? ROW_W : COORD_WIDTH;
  localparam int IDX_W       = 3;
  // Exact product, sum of three products, rounded sum, and sum with offset.
  localparam int PROD_W      = COORD_WIDTH + COEF_WIDTH;
  localparam int SUM_W       = PROD_W + 2;
  localparam int RND_W       = SUM_W - FRAC_BITS;
  localparam int RES_W       = RND_W + 1;

  typedef enum logic [IDX_W-1:0] {
    REG_ROT_ROW_0 = 3'd0,
    REG_ROT_ROW_1 = 3'd1,
    REG_ROT_ROW_2 = 3'd2,
    REG_OFFSET_X  = 3'd3,
    REG_OFFSET_Y  = 3'd4,
    REG_OFFSET_Z  = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] in_x;
    logic signed [COORD_WIDTH-1:0] in_y;
    logic signed [COORD_WIDTH-1:0] in_z;
  } point_in_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] out_x;
    logic signed [COORD_WIDTH-1:0] out_y;
    logic signed [COORD_WIDTH-1:0] out_z;
    logic                          clipped;
  } point_out_t;

  // coef[row][col], offset[row]; all two's complement.
  typedef struct packed {
    logic [AXES-1:0][AXES-1:0][COEF_WIDTH-1:0] coef;
    logic [AXES-1:0][COORD_WIDTH-1:0]          offset;
  } xform_cfg_t;

  typedef logic [AXES-1:0][AXES-1:0][PROD_W-1:0] prod_mat_t;
  typedef logic [AXES-1:0][SUM_W-1:0]            sum_vec_t;

endpackage

@@ design/rpt_cfg_regs.sv @@
// Configuration registers: rotation rows and translation offsets.
module rpt_cfg_regs
  import rpt_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  output xform_cfg_t       cfg
);

  logic [AXES-1:0][ROW_W-1:0]       rot_row;
  logic [AXES-1:0][COORD_WIDTH-1:0] offset;

  // The user writes only with the pipeline empty; unchecked, none is held off.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < AXES; r++) begin
        // Identity: 1.0 on the diagonal, zero elsewhere in the row.
        rot_row[r] <= ROW_W'(1) << (r * COEF_WIDTH + FRAC_BITS);
        offset[r]  <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_ROT_ROW_0: rot_row[0] <= cfg_data[ROW_W-1:0];
        REG_ROT_ROW_1: rot_row[1] <= cfg_data[ROW_W-1:0];
        REG_ROT_ROW_2: rot_row[2] <= cfg_data[ROW_W-1:0];
        REG_OFFSET_X:  offset[0]  <= cfg_data[COORD_WIDTH-1:0];
        REG_OFFSET_Y:  offset[1]  <= cfg_data[COORD_WIDTH-1:0];
        REG_OFFSET_Z:  offset[2]  <= cfg_data[COORD_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int r = 0; r < AXES; r++) begin
      for (int c = 0; c < AXES; c++) begin
        cfg.coef[r][c] = rot_row[r][c*COEF_WIDTH +: COEF_WIDTH];
      end
      cfg.offset[r] = offset[r];
    end
  end

endmodule

@@ design/rpt_mult.sv @@
// First pipeline stage: the nine coefficient by coordinate products.
module rpt_mult
  import rpt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       valid_in,
  output logic       ready_up,
  input  logic       ready_down,
  input  point_in_t  point,
  input  xform_cfg_t cfg,
  output logic       valid,
  output prod_mat_t  prod
);

  logic signed [COORD_WIDTH-1:0] coord [AXES];
  logic signed [COEF_WIDTH-1:0]  coef  [AXES][AXES];
  logic signed [PROD_W-1:0]      prod_next [AXES][AXES];

  assign coord[0] = point.in_x;
  assign coord[1] = point.in_y;
  assign coord[2] = point.in_z;

  assign ready_up = !valid || ready_down;

  always_comb begin
    for (int r = 0; r < AXES; r++) begin
      for (int c = 0; c < AXES; c++) begin
        coef[r][c]      = $signed(cfg.coef[r][c]);
        prod_next[r][c] = coef[r][c] * coord[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready_up) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_up && valid_in) begin
      for (int r = 0; r < AXES; r++) begin
        for (int c = 0; c < AXES; c++) begin
          prod[r][c] <= prod_next[r][c];
        end
      end
    end
  end

endmodule

@@ design/rpt_sum.sv @@
// Second pipeline stage: row sums of the products plus the rounding half.
module rpt_sum
  import rpt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      valid_in,
  output logic      ready_up,
  input  logic      ready_down,
  input  prod_mat_t prod,
  output logic      valid,
  output sum_vec_t  sum
);

  localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (FRAC_BITS - 1);

  logic signed [SUM_W-1:0] sum_next [AXES];

  assign ready_up = !valid || ready_down;

  always_comb begin
    for (int r = 0; r < AXES; r++) begin
      sum_next[r] = SUM_W'($signed(prod[r][0])) + SUM_W'($signed(prod[r][1]))
                  + SUM_W'($signed(prod[r][2])) + ROUND_HALF;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready_up) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_up && valid_in) begin
      for (int r = 0; r < AXES; r++) begin
        sum[r] <= sum_next[r];
      end
    end
  end

endmodule

@@ design/rpt_sat.sv @@
// Last pipeline stage: scale, add the offset, saturate, and hold the output word.
module rpt_sat
  import rpt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       valid_in,
  output logic       ready_up,
  input  logic       out_stall,
  input  sum_vec_t   sum,
  input  xform_cfg_t cfg,
  output logic       out_valid,
  output point_out_t out_data
);

  logic signed [RND_W-1:0]       rounded [AXES];
  logic signed [RES_W-1:0]       total   [AXES];
  logic signed [COORD_WIDTH-1:0] lane    [AXES];
  logic [AXES-1:0]               lane_clip;
  point_out_t                    out_next;

  assign ready_up = !out_valid || !out_stall;

  always_comb begin
    for (int r = 0; r < AXES; r++) begin
      // The rounding half is already in the sum, so dropping the fraction
      // bits gives floor, that is round half up.
      rounded[r] = $signed(sum[r][SUM_W-1:FRAC_BITS]);
      total[r]   = RES_W'(rounded[r]) + RES_W'($signed(cfg.offset[r]));
      // In range when every bit above the result's sign bit repeats it.
      if (total[r][RES_W-1:COORD_WIDTH-1] == '0 || total[r][RES_W-1:COORD_WIDTH-1] == '1) begin
        lane[r]      = total[r][COORD_WIDTH-1:0];
        lane_clip[r] = 1'b0;
      end else begin
        lane[r]      = total[r][RES_W-1] ? {1'b1, {(COORD_WIDTH-1){1'b0}}}
                                         : {1'b0, {(COORD_WIDTH-1){1'b1}}};
        lane_clip[r] = 1'b1;
      end
    end
    out_next.out_x   = lane[0];
    out_next.out_y   = lane[1];
    out_next.out_z   = lane[2];
    out_next.clipped = |lane_clip;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready_up) begin
      out_valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_up && valid_in) begin
      out_data <= out_next;
    end
  end

endmodule

@@ design/rigid_point_transform_core.sv @@
// Top level of the rigid point transform: out = R * p (Q2.14, rounded) + T, saturated.
//
// The input channel (in_valid, in_stall, in_data) takes one word per unstalled cycle.
// The output channel (out_valid, out_stall, out_data) returns one transformed word
// per point, in order, with clipped set when any coordinate was saturated to 32 bits.
// A word moves at a rising edge where valid is high and stall is low.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) writes the
// three rotation rows (index 0 to 2) and the offsets x, y, z (index 3 to 5); other
// indexes are ignored. cfg_ready is always high. Writes belong to idle periods only.
//
// The stages are products, row sums, then round, offset and saturate into the
// output register. It accepts one point per cycle while in_stall is low; each of the
// three stages holds one point, and the nine 16 by 32 multipliers set the first stage.
// When out_stall is high the output word holds and the stages behind it fill up;
// in_stall rises only once every stage holds a point, so a bubble never blocks.
// Synchronous reset empties the pipeline and loads the identity rotation with
// zero offsets.
module rigid_point_transform_core
  import rpt_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  point_in_t        in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output point_out_t       out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

`include "assert_macros.svh"

  xform_cfg_t cfg;

  // Per stage: valid of the held point and whether the stage can take a new one.
  logic      mult_valid;
  logic      mult_ready;
  prod_mat_t prod;
  logic      sum_valid;
  logic      sum_ready;
  sum_vec_t  sum;
  logic      sat_ready;

  rpt_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rpt_mult u_mult (
    .clk        (clk),
    .rst        (rst),
    .valid_in   (in_valid),
    .ready_up   (mult_ready),
    .ready_down (sum_ready),
    .point      (in_data),
    .cfg        (cfg),
    .valid      (mult_valid),
    .prod       (prod)
  );

  rpt_sum u_sum (
    .clk        (clk),
    .rst        (rst),
    .valid_in   (mult_valid),
    .ready_up   (sum_ready),
    .ready_down (sat_ready),
    .prod       (prod),
    .valid      (sum_valid),
    .sum        (sum)
  );

  rpt_sat u_sat (
    .clk       (clk),
    .rst       (rst),
    .valid_in  (sum_valid),
    .ready_up  (sat_ready),
    .out_stall (out_stall),
    .sum       (sum),
    .cfg       (cfg),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // A stage with a free slot takes the word from behind it, so the input is
  // held off only when the whole pipeline is full and the output is stalled.
  assign in_stall = !mult_ready;

  // Reset always leaves the output channel empty.
  `ASSERT_ALW(a_reset_empties, clk, rst |=> !out_valid)
  // The input is held off only with every stage occupied and the output stalled.
  `ASSERT_CHK(a_stall_when_full, clk, rst,
    in_stall |-> (mult_valid && sum_valid && out_valid && out_stall))
  // A clipped word carries a coordinate whose bits below the sign bit are all equal.
  `ASSERT_CHK(a_clip_at_limit, clk, rst,
    (out_valid && out_data.clipped) |->
      (out_data.out_x[COORD_WIDTH-2:0] == '0 || out_data.out_x[COORD_WIDTH-2:0] == '1 ||
       out_data.out_y[COORD_WIDTH-2:0] == '0 || out_data.out_y[COORD_WIDTH-2:0] == '1 ||
       out_data.out_z[COORD_WIDTH-2:0] == '0 || out_data.out_z[COORD_WIDTH-2:0] == '1))
  // With the first two stages empty, nothing new can reach the output register.
  `ASSERT_CHK(a_no_phantom_word, clk, rst,
    (!mult_valid && !sum_valid && !out_valid) |=> !out_valid)

endmodule

@@ tb/sv/rigid_point_transform_core_test.sv @@
// Self-checking testbench for the rigid point transform core: directed table, then random phases.
module rigid_point_transform_core_test;
  import rpt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Generous cycle budget. The slowest correct run is about 1100 words, each with a
  // full input gap and a full output stall, plus the drain after every phase.
  localparam int CYCLE_LIMIT     = 400000;
  localparam int PHASES          = 7;
  localparam int WORDS_PER_PHASE = 150;
  localparam int TAIL_CYCLES     = 8;

  // Indexes past the last register; the block must ignore writes to them.
  localparam logic [IDX_W-1:0] IDX_SPARE_LO = 3'd6;
  localparam logic [IDX_W-1:0] IDX_SPARE_HI = 3'd7;

  localparam logic signed [COORD_WIDTH-1:0] C_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [COORD_WIDTH-1:0] C_MIN = 32'sh8000_0000;

  // Coefficient codes in Q2.14: the code with only the sign bit set is -2.0 exactly.
  localparam logic [COEF_WIDTH-1:0] COEF_NEG2 = 16'h8000;
  localparam logic [COEF_WIDTH-1:0] COEF_TOP  = 16'h7FFF;
  localparam logic [COEF_WIDTH-1:0] COEF_ONE  = 16'h4000;
  localparam logic [COEF_WIDTH-1:0] COEF_NEG1 = 16'hC000;

  logic             clk;
  logic             rst;
  logic             in_valid;
  logic             in_stall;
  point_in_t        in_data;
  logic             out_valid;
  logic             out_stall;
  point_out_t       out_data;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  rigid_point_transform_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // One row of the directed table: either a register write or a point word. Where the
  // result is obvious from the arithmetic, the expected word is typed in by hand.
  typedef struct {
    bit               is_write;
    logic [IDX_W-1:0] idx;
    logic [CFG_W-1:0] val;
    point_in_t        pt;
    bit               known;
    point_out_t       golden;
  } stim_row_t;

  // Mirror of the register file: signed coefficients per row and column, and offsets.
  logic signed [COEF_WIDTH-1:0]  rot_coef [AXES][AXES];
  logic signed [COORD_WIDTH-1:0] trans    [AXES];

  point_out_t expected_pts [$];
  stim_row_t  plan [$];

  int points_sent;
  int points_checked;
  int reg_writes;
  int error_count;
  int cycles;
  int gap_pct;
  bit quiet;

  // Exact rotation sum, scaled by 2^-14 with round-half-up, then offset and saturation.
  // Products fit in 48 bits and the sum of three in 50, so 64-bit math is exact.
  function automatic point_out_t transform_point(point_in_t p);
    longint     crd [AXES];
    longint     res [AXES];
    longint     acc;
    longint     lim_hi;
    longint     lim_lo;
    point_out_t q;
    int         r;
    int         c;
    lim_hi = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
    lim_lo = -lim_hi - 1;
    crd[0] = longint'($signed(p.in_x));
    crd[1] = longint'($signed(p.in_y));
    crd[2] = longint'($signed(p.in_z));
    q.clipped = 1'b0;
    for (r = 0; r < AXES; r++) begin
      acc = 0;
      for (c = 0; c < AXES; c++) begin
        acc += longint'(rot_coef[r][c]) * crd[c];
      end
      res[r] = ((acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS)
               + longint'(trans[r]);
      if (res[r] > lim_hi) begin
        res[r] = lim_hi;
        q.clipped = 1'b1;
      end else if (res[r] < lim_lo) begin
        res[r] = lim_lo;
        q.clipped = 1'b1;
      end
    end
    q.out_x = res[0][COORD_WIDTH-1:0];
    q.out_y = res[1][COORD_WIDTH-1:0];
    q.out_z = res[2][COORD_WIDTH-1:0];
    return q;
  endfunction

  function automatic void plan_write(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    stim_row_t row;
    row.is_write = 1'b1;
    row.idx      = idx;
    row.val      = val;
    row.pt       = '0;
    row.known    = 1'b0;
    row.golden   = '0;
    plan.push_back(row);
  endfunction

  function automatic void plan_point(point_in_t pt, bit known, point_out_t golden);
    stim_row_t row;
    row.is_write = 1'b0;
    row.idx      = '0;
    row.val      = '0;
    row.pt       = pt;
    row.known    = known;
    row.golden   = golden;
    plan.push_back(row);
  endfunction

  // Coordinates lean on the full 32-bit range but also visit the extremes and
  // small values, where rounding of the fraction is easy to get wrong.
  function automatic logic signed [COORD_WIDTH-1:0] random_coord();
    logic signed [COORD_WIDTH-1:0] v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: v = C_MIN;
          1: v = C_MAX;
          2: v = '0;
          3: v = -32'sd1;
          default: v = 32'sd1;
        endcase
      end
      1, 2: v = $urandom_range(0, 131071) - 65536;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Style 0 is raw random codes, style 1 is rotation-like values within +-1.0,
  // and any other style picks among the extreme and unit codes.
  function automatic logic [CFG_W-1:0] pick_row(int style);
    logic [CFG_W-1:0]      row;
    logic [COEF_WIDTH-1:0] cf;
    int                    c;
    row = '0;
    for (c = 0; c < AXES; c++) begin
      case (style)
        0: cf = COEF_WIDTH'($urandom);
        1: cf = COEF_WIDTH'($urandom_range(0, 32768) - 16384);
        default: begin
          case ($urandom_range(0, 4))
            0: cf = COEF_NEG2;
            1: cf = COEF_TOP;
            2: cf = COEF_ONE;
            3: cf = COEF_NEG1;
            default: cf = '0;
          endcase
        end
      endcase
      row[c*COEF_WIDTH +: COEF_WIDTH] = cf;
    end
    return row;
  endfunction

  // Offsets carry random junk above bit 31, which the block has to drop.
  function automatic logic [CFG_W-1:0] pick_offset(int style);
    logic [COORD_WIDTH-1:0] v;
    case (style)
      0: v = '0;
      1: v = $urandom;
      2: v = $urandom_range(0, 1) ? C_MAX : C_MIN;
      default: v = $urandom_range(0, 2047) - 1024;
    endcase
    return {(CFG_W - COORD_WIDTH)'($urandom), v};
  endfunction

  // Holds cfg_valid up until the write handshake and then updates the mirror.
  // The caller lowers cfg_valid once the batch of writes is done, so that
  // back-to-back writes never lower and raise it in the same time step.
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    int c;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_ROT_ROW_0, REG_ROT_ROW_1, REG_ROT_ROW_2: begin
        for (c = 0; c < AXES; c++) begin
          rot_coef[idx[1:0]][c] = val[c*COEF_WIDTH +: COEF_WIDTH];
        end
      end
      REG_OFFSET_X: trans[0] = val[COORD_WIDTH-1:0];
      REG_OFFSET_Y: trans[1] = val[COORD_WIDTH-1:0];
      REG_OFFSET_Z: trans[2] = val[COORD_WIDTH-1:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  // Sends one point word, sometimes after an idle burst. The expected result is
  // queued at the edge where the word is taken.
  task automatic push_point(input point_in_t pt, input bit known, input point_out_t golden);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= pt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_pts.push_back(known ? golden : transform_point(pt));
    points_sent++;
  endtask

  // Register writes are only legal while the pipeline is empty. Every word gives
  // a result, so once the queue is empty the pipeline is empty as well.
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_pts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // The receiver stalls in random bursts with free-running stretches between them,
  // and stops stalling once the quiet tail begins.
  initial begin : out_stall_gen
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (quiet) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end
    end
  end

  // Every word taken from the output is matched, field by field, against the
  // oldest expected result.
  always @(posedge clk) begin : result_check
    point_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_pts.size() == 0) begin
        if (error_count < 10) begin
          $display("unexpected result word x=%0d y=%0d z=%0d clipped=%0b",
                   $signed(out_data.out_x), $signed(out_data.out_y),
                   $signed(out_data.out_z), out_data.clipped);
        end
        error_count++;
      end else begin
        want = expected_pts.pop_front();
        points_checked++;
        if (out_data.out_x !== want.out_x || out_data.out_y !== want.out_y ||
            out_data.out_z !== want.out_z || out_data.clipped !== want.clipped) begin
          if (error_count < 10) begin
            $display("result %0d: expected x=%0d y=%0d z=%0d clipped=%0b",
                     points_checked, $signed(want.out_x), $signed(want.out_y),
                     $signed(want.out_z), want.clipped);
            $display("result %0d: actual   x=%0d y=%0d z=%0d clipped=%0b",
                     points_checked, $signed(out_data.out_x), $signed(out_data.out_y),
                     $signed(out_data.out_z), out_data.clipped);
          end
          error_count++;
        end
      end
    end
  end

  initial begin : stimulus
    int        phase;
    int        k;
    int        r;
    bit        last_was_point;
    stim_row_t row;

    // Every input of the block is known from time zero on.
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    quiet     = 1'b0;
    gap_pct   = 20;

    // The mirror starts out at the reset state: identity rotation, zero offsets.
    for (r = 0; r < AXES; r++) begin
      for (k = 0; k < AXES; k++) begin
        rot_coef[r][k] = (r == k) ? COEF_ONE : '0;
      end
      trans[r] = '0;
    end

    // Under the reset identity every point must come back unchanged.
    plan_point('{32'sd0, 32'sd0, 32'sd0}, 1'b1, '{32'sd0, 32'sd0, 32'sd0, 1'b0});
    plan_point('{C_MAX, C_MIN, -32'sd1}, 1'b1, '{C_MAX, C_MIN, -32'sd1, 1'b0});
    plan_point('{C_MIN, C_MAX, 32'sd1}, 1'b1, '{C_MIN, C_MAX, 32'sd1, 1'b0});
    plan_point('{32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0001_2345}, 1'b1,
               '{32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0001_2345, 1'b0});
    // A unit offset pushes the top coordinate over and saturates it.
    plan_write(REG_OFFSET_X, 48'h0000_0000_0001);
    plan_point('{C_MAX, 32'sd0, 32'sd0}, 1'b1, '{C_MAX, 32'sd0, 32'sd0, 1'b1});
    // The junk above bit 31 must be dropped, leaving an offset of -1.
    plan_write(REG_OFFSET_Y, 48'hABCD_FFFF_FFFF);
    plan_point('{32'sd0, C_MIN, 32'sd0}, 1'b1, '{32'sd1, C_MIN, 32'sd0, 1'b1});
    plan_write(REG_OFFSET_Z, {16'h1234, C_MIN});
    plan_point('{32'sd0, 32'sd0, -32'sd1}, 1'b1, '{32'sd1, -32'sd1, C_MIN, 1'b1});
    plan_point('{C_MIN, C_MAX, C_MAX}, 1'b1,
               '{C_MIN + 32'sd1, C_MAX - 32'sd1, -32'sd1, 1'b0});
    // Every coefficient at -2.0, every one at the top code, and a zero row.
    plan_write(REG_ROT_ROW_0, {COEF_NEG2, COEF_NEG2, COEF_NEG2});
    plan_write(REG_ROT_ROW_1, {COEF_TOP, COEF_TOP, COEF_TOP});
    plan_write(REG_ROT_ROW_2, 48'h0);
    plan_point('{C_MIN, C_MIN, C_MIN}, 1'b0, '0);
    plan_point('{C_MAX, C_MAX, C_MAX}, 1'b0, '0);
    plan_point('{32'sd1, -32'sd1, 32'sd0}, 1'b0, '0);
    plan_point('{32'sd0, 32'sd0, 32'sd0}, 1'b0, '0);
    // Half-way fractions: +0.5 and -0.5 coefficients, and the smallest step.
    plan_write(REG_ROT_ROW_0, 48'h0000_0000_2000);
    plan_write(REG_ROT_ROW_1, 48'h0000_E000_0000);
    plan_write(REG_ROT_ROW_2, 48'h0001_0000_0000);
    plan_write(REG_OFFSET_X, 48'h0);
    plan_write(REG_OFFSET_Y, 48'h0);
    plan_write(REG_OFFSET_Z, 48'h0);
    plan_point('{32'sd1, 32'sd1, 32'sd8191}, 1'b0, '0);
    plan_point('{-32'sd1, -32'sd1, 32'sd8192}, 1'b0, '0);
    plan_point('{32'sd3, 32'sd3, -32'sd8193}, 1'b0, '0);
    plan_point('{-32'sd3, -32'sd3, C_MAX}, 1'b0, '0);
    // Writes past the last register must leave the transform as it was.
    plan_write(IDX_SPARE_LO, 48'hFFFF_FFFF_FFFF);
    plan_write(IDX_SPARE_HI, 48'h8000_8000_8000);
    plan_point('{32'sd5, 32'sd5, 32'sd5}, 1'b0, '0);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed table. The pipeline is drained before any write that
    // follows a point, and cfg_valid drops before the next point goes out.
    last_was_point = 1'b1;
    foreach (plan[i]) begin
      row = plan[i];
      if (row.is_write) begin
        if (last_was_point) settle();
        write_reg(row.idx, row.val);
        last_was_point = 1'b0;
      end else begin
        if (!last_was_point) cfg_valid <= 1'b0;
        push_point(row.pt, row.known, row.golden);
        last_was_point = 1'b1;
      end
    end

    // Random phases, each with a fresh setting of all six registers. The last
    // phase runs with no idling on either side.
    for (phase = 0; phase < PHASES; phase++) begin
      settle();
      if ($urandom_range(0, 1)) begin
        write_reg($urandom_range(0, 1) ? IDX_SPARE_LO : IDX_SPARE_HI,
                  {16'($urandom), 32'($urandom)});
      end
      write_reg(REG_ROT_ROW_0, pick_row(phase % 3));
      write_reg(REG_ROT_ROW_1, pick_row((phase + 1) % 3));
      write_reg(REG_ROT_ROW_2, pick_row(phase % 3));
      write_reg(REG_OFFSET_X, pick_offset(phase % 4));
      write_reg(REG_OFFSET_Y, pick_offset((phase + 1) % 4));
      write_reg(REG_OFFSET_Z, pick_offset((phase + 2) % 4));
      cfg_valid <= 1'b0;
      quiet = (phase == PHASES - 1);
      if (quiet) begin
        gap_pct = 0;
      end else begin
        case ($urandom_range(0, 2))
          0: gap_pct = 0;
          1: gap_pct = 15;
          default: gap_pct = 40;
        endcase
      end
      for (k = 0; k < WORDS_PER_PHASE; k++) begin
        push_point('{random_coord(), random_coord(), random_coord()}, 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    while (expected_pts.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d point words and checked %0d results across %0d register writes,",
             points_sent, points_checked, reg_writes);
    $display("covering identity, saturation, -2.0 coefficients, rounding and ignored indexes.");
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+design
design/rpt_pkg.sv
design/rpt_cfg_regs.sv
design/rpt_mult.sv
design/rpt_sum.sv
design/rpt_sat.sv
design/rigid_point_transform_core.sv
tb/sv/rigid_point_transform_core_test.sv
